FILE: rtl/gdc_pkg.sv
// shared types, codes and the stencil term table for the divergence and curl core
`default_nettype none

package gdc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DRAIN,
    ST_FIN,
    ST_DONE
  } state_t;

  // axis of a difference, also used for the vector component
  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_X      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Y      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_Z      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_INV_DX = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_INV_DY = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_INV_DZ = 3'd5;

  // fixed field widths
  localparam int CFG_DATA_W = 32;
  localparam int SIZE_W     = 5;
  localparam int IDX_W      = 4;
  localparam int FACTOR_W   = 32;
  localparam int VEC_W      = 32;
  localparam int RES_W      = 32;
  localparam int STATUS_W   = 2;

  // reset values of the configuration registers
  localparam logic [SIZE_W-1:0]   SIZE_RESET   = 5'd16;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 32'd32768;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd2;

  // multiplier chunking of the difference magnitude
  localparam int CHUNK_W = 16;

  // sequencer counter widths and end points
  localparam int TERM_W    = 4;
  localparam int READ_W    = 3;
  localparam int RES_SEL_W = 2;
  localparam logic [READ_W-1:0]    READ_LAST = 3'd6;
  localparam logic [RES_SEL_W-1:0] RES_LAST  = 2'd3;

  // one product term of a result: difference axis, component, sign flip,
  // and whether it closes the current result
  typedef struct packed {
    axis_t axis;
    axis_t comp;
    logic  flip;
    logic  last;
  } term_info_t;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } mac_ctrl_t;

  // rounded and saturated accumulator value
  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             sat;
  } mac_res_t;

  // term order: divergence (3 terms), then curl x, y, z (2 terms each)
  function automatic term_info_t term_info(input logic [TERM_W-1:0] t);
    term_info_t ti;
    ti = '{axis: AXIS_X, comp: AXIS_X, flip: 1'b0, last: 1'b0};
    case (t)
      4'd0: ti = '{axis: AXIS_X, comp: AXIS_X, flip: 1'b0, last: 1'b0};
      4'd1: ti = '{axis: AXIS_Y, comp: AXIS_Y, flip: 1'b0, last: 1'b0};
      4'd2: ti = '{axis: AXIS_Z, comp: AXIS_Z, flip: 1'b0, last: 1'b1};
      4'd3: ti = '{axis: AXIS_Y, comp: AXIS_Z, flip: 1'b0, last: 1'b0};
      4'd4: ti = '{axis: AXIS_Z, comp: AXIS_Y, flip: 1'b1, last: 1'b1};
      4'd5: ti = '{axis: AXIS_Z, comp: AXIS_X, flip: 1'b0, last: 1'b0};
      4'd6: ti = '{axis: AXIS_X, comp: AXIS_Z, flip: 1'b1, last: 1'b1};
      4'd7: ti = '{axis: AXIS_X, comp: AXIS_Y, flip: 1'b0, last: 1'b0};
      4'd8: ti = '{axis: AXIS_Y, comp: AXIS_X, flip: 1'b1, last: 1'b1};
      default: ti = '{axis: AXIS_X, comp: AXIS_X, flip: 1'b0, last: 1'b1};
    endcase
    return ti;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/gdc_vec_mem.sv
// vector grid storage: one write port, one registered read port
`default_nettype none

module gdc_vec_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 96
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/gdc_mac.sv
// shared chunked multiply-accumulate unit with rounding and saturation
`default_nettype none

module gdc_mac #(
  parameter  int COMP_WIDTH = 32,
  localparam int DW         = COMP_WIDTH + 1,
  localparam int NCH        = (DW + gdc_pkg::CHUNK_W - 1) / gdc_pkg::CHUNK_W,
  localparam int CSW        = $clog2(NCH)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire gdc_pkg::mac_ctrl_t               ctrl,
  input  wire logic [CSW-1:0]                   chunk,
  input  wire logic [COMP_WIDTH:0]              mag,
  input  wire logic [gdc_pkg::FACTOR_W-1:0]     factor,
  output gdc_pkg::mac_res_t                     res
);

  localparam int PADW = NCH * gdc_pkg::CHUNK_W;
  localparam int PW   = gdc_pkg::CHUNK_W + gdc_pkg::FACTOR_W;
  localparam int ACCW = COMP_WIDTH + 36;
  localparam int RW   = gdc_pkg::RES_W;

  logic [PADW-1:0]              mag_pad;
  logic [gdc_pkg::CHUNK_W-1:0]  mag_chunk;
  logic [PW-1:0]                prod;
  logic [CSW-1:0]               p_chunk;
  logic                         p_neg;
  logic                         p_vld;
  logic signed [ACCW-1:0]       addend;
  logic signed [ACCW-1:0]       addend_s;
  logic signed [ACCW-1:0]       acc;
  logic signed [ACCW-1:0]       acc_next;
  logic signed [ACCW-1:0]       rnd;
  logic [ACCW-RW-16:0]          upper;
  logic                         fits;

  // pick the chunk of the magnitude for this pass
  assign mag_pad   = PADW'(mag);
  assign mag_chunk = mag_pad[chunk*gdc_pkg::CHUNK_W +: gdc_pkg::CHUNK_W];

  // multiply stage
  always_ff @(posedge clk) begin
    prod    <= mag_chunk * factor;
    p_chunk <= chunk;
    p_neg   <= ctrl.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= ctrl.en;
    end
  end

  // accumulate stage: shifted partial product, signed by the term
  always_comb begin
    addend   = ACCW'(prod) << (p_chunk * gdc_pkg::CHUNK_W);
    addend_s = p_neg ? -addend : addend;
    acc_next = acc;
    if (ctrl.clr) begin
      acc_next = '0;
    end else if (p_vld) begin
      acc_next = acc + addend_s;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // round half up to q16.16 and clamp to 32 bits
  always_comb begin
    rnd   = acc + ACCW'(32'h0000_8000);
    upper = rnd[ACCW-1:RW+15];
    fits  = (&upper) | ~(|upper);
    res.sat = ~fits;
    if (fits) begin
      res.value = rnd[RW+15:16];
    end else if (rnd[ACCW-1]) begin
      res.value = {1'b1, {(RW-1){1'b0}}};
    end else begin
      res.value = {1'b0, {(RW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/grid_divergence_curl_stencil_core.sv
// top level: vector grid with central-difference divergence and curl queries
// write: taken without a result; the next item can follow right away
// query: the sequencer reads six neighbors on the single memory read port, then runs nine
//   terms, each in 16-bit chunks of the difference, through the shared 16 x 32 multiplier;
//   a new item is taken only once the result is loaded and the sequencer is back in idle
//   out-of-range query: no reads, straight to the result
// reset clears sequencer and output valid, sets config registers to their reset values; grid contents undefined
`default_nettype none

module grid_divergence_curl_stencil_core #(
  parameter int MAX_DIM    = 16,
  parameter int COMP_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                req_type,
  input  wire logic [gdc_pkg::IDX_W-1:0]           index_x,
  input  wire logic [gdc_pkg::IDX_W-1:0]           index_y,
  input  wire logic [gdc_pkg::IDX_W-1:0]           index_z,
  input  wire logic signed [gdc_pkg::VEC_W-1:0]    vec_x,
  input  wire logic signed [gdc_pkg::VEC_W-1:0]    vec_y,
  input  wire logic signed [gdc_pkg::VEC_W-1:0]    vec_z,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [gdc_pkg::RES_W-1:0]         divergence,
  output logic signed [gdc_pkg::RES_W-1:0]         curl_x,
  output logic signed [gdc_pkg::RES_W-1:0]         curl_y,
  output logic signed [gdc_pkg::RES_W-1:0]         curl_z,
  output logic [gdc_pkg::STATUS_W-1:0]             status,
  // configuration write port
  input  wire logic                                cfg_we,
  input  wire logic [gdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [gdc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int VW    = 3 * COMP_WIDTH;
  localparam int DW    = COMP_WIDTH + 1;
  localparam int NCH   = (DW + gdc_pkg::CHUNK_W - 1) / gdc_pkg::CHUNK_W;
  localparam int CSW   = $clog2(NCH);
  localparam int EW    = ($clog2(MAX_DIM + 1) > gdc_pkg::SIZE_W) ?
                         $clog2(MAX_DIM + 1) : gdc_pkg::SIZE_W;
  localparam logic [EW-1:0]  DIM_MAX    = EW'(MAX_DIM);
  localparam logic [AW-1:0]  STRIDE_Y   = AW'(MAX_DIM);
  localparam logic [AW-1:0]  STRIDE_Z   = AW'(MAX_DIM * MAX_DIM);
  localparam logic [CSW-1:0] CHUNK_LAST = CSW'(NCH - 1);

  // neighbor read steps
  localparam logic [gdc_pkg::READ_W-1:0] NB_LEFT  = 3'd0;
  localparam logic [gdc_pkg::READ_W-1:0] NB_RIGHT = 3'd1;
  localparam logic [gdc_pkg::READ_W-1:0] NB_DOWN  = 3'd2;
  localparam logic [gdc_pkg::READ_W-1:0] NB_UP    = 3'd3;
  localparam logic [gdc_pkg::READ_W-1:0] NB_BACK  = 3'd4;
  localparam logic [gdc_pkg::READ_W-1:0] NB_FRONT = 3'd5;

  // configuration registers
  logic [gdc_pkg::SIZE_W-1:0]   size_x;
  logic [gdc_pkg::SIZE_W-1:0]   size_y;
  logic [gdc_pkg::SIZE_W-1:0]   size_z;
  logic [gdc_pkg::FACTOR_W-1:0] half_inv_dx;
  logic [gdc_pkg::FACTOR_W-1:0] half_inv_dy;
  logic [gdc_pkg::FACTOR_W-1:0] half_inv_dz;

  // sequencer
  gdc_pkg::state_t                state;
  gdc_pkg::state_t                state_next;
  logic [gdc_pkg::READ_W-1:0]     rd_cnt;
  logic [gdc_pkg::READ_W-1:0]     cap_step;
  logic [gdc_pkg::TERM_W-1:0]     term;
  logic [CSW-1:0]                 chunk_cnt;
  logic [gdc_pkg::RES_SEL_W-1:0]  res_cnt;
  gdc_pkg::term_info_t            ti;

  // query data
  logic [gdc_pkg::IDX_W-1:0]      qx;
  logic [gdc_pkg::IDX_W-1:0]      qy;
  logic [gdc_pkg::IDX_W-1:0]      qz;
  logic                           bad;
  logic                           sat_any;
  logic [VW-1:0]                  minus_vec;
  logic signed [DW-1:0]           diff_reg [3][3];
  logic [gdc_pkg::RES_W-1:0]      res_val [4];

  // combinational helpers
  logic [EW-1:0]                  eff_x;
  logic [EW-1:0]                  eff_y;
  logic [EW-1:0]                  eff_z;
  logic                           in_ok;
  logic                           in_xfer;
  logic [EW-1:0]                  nb_x;
  logic [EW-1:0]                  nb_y;
  logic [EW-1:0]                  nb_z;
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [VW-1:0]                  mem_wdata;
  logic [AW-1:0]                  mem_raddr;
  logic [VW-1:0]                  mem_rdata;
  logic signed [DW-1:0]           term_diff;
  logic [DW-1:0]                  term_mag;
  logic [gdc_pkg::FACTOR_W-1:0]   term_factor;
  gdc_pkg::mac_ctrl_t             mac_ctrl;
  gdc_pkg::mac_res_t              mac_res;
  logic                           out_load;

  // flat address of a grid point
  function automatic logic [AW-1:0] addr_of(input logic [EW-1:0] x,
                                            input logic [EW-1:0] y,
                                            input logic [EW-1:0] z);
    return AW'(x) + AW'(y) * STRIDE_Y + AW'(z) * STRIDE_Z;
  endfunction

  // neighbor below, clamped at zero
  function automatic logic [EW-1:0] step_lo(input logic [gdc_pkg::IDX_W-1:0] v);
    return (v != '0) ? EW'(v) - EW'(1) : EW'(v);
  endfunction

  // neighbor above, clamped at the grid edge
  function automatic logic [EW-1:0] step_hi(input logic [gdc_pkg::IDX_W-1:0] v,
                                            input logic [EW-1:0] eff);
    return ((EW'(v) + EW'(1)) < eff) ? EW'(v) + EW'(1) : EW'(v);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_x      <= gdc_pkg::SIZE_RESET;
      size_y      <= gdc_pkg::SIZE_RESET;
      size_z      <= gdc_pkg::SIZE_RESET;
      half_inv_dx <= gdc_pkg::FACTOR_RESET;
      half_inv_dy <= gdc_pkg::FACTOR_RESET;
      half_inv_dz <= gdc_pkg::FACTOR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gdc_pkg::CFG_SIZE_X:      size_x      <= cfg_data[gdc_pkg::SIZE_W-1:0];
        gdc_pkg::CFG_SIZE_Y:      size_y      <= cfg_data[gdc_pkg::SIZE_W-1:0];
        gdc_pkg::CFG_SIZE_Z:      size_z      <= cfg_data[gdc_pkg::SIZE_W-1:0];
        gdc_pkg::CFG_HALF_INV_DX: half_inv_dx <= cfg_data;
        gdc_pkg::CFG_HALF_INV_DY: half_inv_dy <= cfg_data;
        gdc_pkg::CFG_HALF_INV_DZ: half_inv_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes and range check of the incoming index
  always_comb begin
    eff_x = (EW'(size_x) > DIM_MAX) ? DIM_MAX : EW'(size_x);
    eff_y = (EW'(size_y) > DIM_MAX) ? DIM_MAX : EW'(size_y);
    eff_z = (EW'(size_z) > DIM_MAX) ? DIM_MAX : EW'(size_z);
    in_ok = (EW'(index_x) < eff_x) && (EW'(index_y) < eff_y) && (EW'(index_z) < eff_z);
  end

  assign in_xfer = in_valid && !in_stall;

  // memory write on an in-range vector write transfer, components wrapped to storage width
  assign mem_we    = in_xfer && (req_type == gdc_pkg::REQ_WRITE) && in_ok;
  assign mem_waddr = addr_of(EW'(index_x), EW'(index_y), EW'(index_z));
  assign mem_wdata = {COMP_WIDTH'(vec_z), COMP_WIDTH'(vec_y), COMP_WIDTH'(vec_x)};

  // neighbor coordinate for the current read step
  always_comb begin
    nb_x = EW'(qx);
    nb_y = EW'(qy);
    nb_z = EW'(qz);
    case (rd_cnt)
      NB_LEFT:  nb_x = step_lo(qx);
      NB_RIGHT: nb_x = step_hi(qx, eff_x);
      NB_DOWN:  nb_y = step_lo(qy);
      NB_UP:    nb_y = step_hi(qy, eff_y);
      NB_BACK:  nb_z = step_lo(qz);
      NB_FRONT: nb_z = step_hi(qz, eff_z);
      default: ;
    endcase
  end

  assign mem_raddr = addr_of(nb_x, nb_y, nb_z);

  gdc_vec_mem #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (VW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // current term: difference, magnitude and axis factor
  always_comb begin
    ti        = gdc_pkg::term_info(term);
    term_diff = diff_reg[ti.axis][ti.comp];
    term_mag  = term_diff[DW-1] ? DW'(-term_diff) : DW'(term_diff);
    case (ti.axis)
      gdc_pkg::AXIS_X: term_factor = half_inv_dx;
      gdc_pkg::AXIS_Y: term_factor = half_inv_dy;
      gdc_pkg::AXIS_Z: term_factor = half_inv_dz;
      default:         term_factor = half_inv_dx;
    endcase
  end

  gdc_mac #(
    .COMP_WIDTH (COMP_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .chunk  (chunk_cnt),
    .mag    (term_mag),
    .factor (term_factor),
    .res    (mac_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gdc_pkg::ST_IDLE: begin
        if (in_valid && (req_type == gdc_pkg::REQ_QUERY)) begin
          state_next = in_ok ? gdc_pkg::ST_READ : gdc_pkg::ST_DONE;
        end
      end
      gdc_pkg::ST_READ: begin
        if (rd_cnt == gdc_pkg::READ_LAST) begin
          state_next = gdc_pkg::ST_MUL;
        end
      end
      gdc_pkg::ST_MUL: begin
        if ((chunk_cnt == CHUNK_LAST) && ti.last) begin
          state_next = gdc_pkg::ST_DRAIN;
        end
      end
      gdc_pkg::ST_DRAIN: state_next = gdc_pkg::ST_FIN;
      gdc_pkg::ST_FIN: begin
        state_next = (res_cnt == gdc_pkg::RES_LAST) ? gdc_pkg::ST_DONE : gdc_pkg::ST_MUL;
      end
      gdc_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = gdc_pkg::ST_IDLE;
        end
      end
      default: state_next = gdc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    mac_ctrl.en  = 1'b0;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.neg = term_diff[DW-1] ^ ti.flip;
    out_load     = 1'b0;
    case (state)
      gdc_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        mac_ctrl.clr = 1'b1;
      end
      gdc_pkg::ST_MUL:  mac_ctrl.en  = 1'b1;
      gdc_pkg::ST_FIN:  mac_ctrl.clr = 1'b1;
      gdc_pkg::ST_DONE: out_load     = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gdc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt    <= '0;
      term      <= '0;
      chunk_cnt <= '0;
      res_cnt   <= '0;
    end else begin
      case (state)
        gdc_pkg::ST_IDLE: begin
          rd_cnt    <= '0;
          term      <= '0;
          chunk_cnt <= '0;
          res_cnt   <= '0;
        end
        gdc_pkg::ST_READ: rd_cnt <= rd_cnt + 1'b1;
        gdc_pkg::ST_MUL: begin
          if (chunk_cnt == CHUNK_LAST) begin
            chunk_cnt <= '0;
            if (!ti.last) begin
              term <= term + 1'b1;
            end
          end else begin
            chunk_cnt <= chunk_cnt + 1'b1;
          end
        end
        gdc_pkg::ST_FIN: begin
          term    <= term + 1'b1;
          res_cnt <= res_cnt + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // query capture, neighbor differences and finished results
  assign cap_step = rd_cnt - 1'b1;

  always_ff @(posedge clk) begin
    if (state == gdc_pkg::ST_IDLE && in_xfer) begin
      qx      <= index_x;
      qy      <= index_y;
      qz      <= index_z;
      bad     <= !in_ok;
      sat_any <= 1'b0;
    end
    if (state == gdc_pkg::ST_READ && rd_cnt != '0) begin
      if (!cap_step[0]) begin
        minus_vec <= mem_rdata;
      end else begin
        for (int c = 0; c < 3; c++) begin
          diff_reg[cap_step[2:1]][c] <=
            DW'($signed(mem_rdata[c*COMP_WIDTH +: COMP_WIDTH])) -
            DW'($signed(minus_vec[c*COMP_WIDTH +: COMP_WIDTH]));
        end
      end
    end
    if (state == gdc_pkg::ST_FIN) begin
      res_val[res_cnt] <= mac_res.value;
      sat_any          <= sat_any | mac_res.sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      divergence <= bad ? '0 : res_val[0];
      curl_x     <= bad ? '0 : res_val[1];
      curl_y     <= bad ? '0 : res_val[2];
      curl_z     <= bad ? '0 : res_val[3];
      if (bad) begin
        status <= gdc_pkg::STATUS_RANGE;
      end else if (sat_any) begin
        status <= gdc_pkg::STATUS_SAT;
      end else begin
        status <= gdc_pkg::STATUS_OK;
      end
    end
  end

  // range errors carry zero results
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == gdc_pkg::STATUS_RANGE) |->
      (divergence == 0) && (curl_x == 0) && (curl_y == 0) && (curl_z == 0))
    else $error("range error result with nonzero fields");

  // a vector write never starts the read sequence
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == gdc_pkg::ST_IDLE) && in_valid && (req_type == gdc_pkg::REQ_WRITE) |=>
      (state == gdc_pkg::ST_IDLE))
    else $error("write transfer left idle");

  // all six neighbors read before the first term
  a_read_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == gdc_pkg::ST_READ) && (rd_cnt == gdc_pkg::READ_LAST) |=>
      (state == gdc_pkg::ST_MUL) && (term == '0) && (chunk_cnt == '0))
    else $error("multiply phase did not start at the first term");

  // accumulator settles in the drain state before the finish state rounds it
  a_drain_fin: assert property (@(posedge clk) disable iff (rst)
    (state == gdc_pkg::ST_DRAIN) |=> (state == gdc_pkg::ST_FIN))
    else $error("drain not followed by finish");

  // a finished query reaches the output as soon as the register is free
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == gdc_pkg::ST_DONE) && !(out_valid && out_stall) |=>
      out_valid && (state == gdc_pkg::ST_IDLE))
    else $error("finished query not loaded into output");

endmodule

`default_nettype wire
